// ----- src/lc4_pkg.sv -----
package lc4_pkg;

   typedef enum logic [1:0] {
      OP_EXEC   = 2'd0,
      OP_WRMEM  = 2'd1,
      OP_WRREG  = 2'd2,
      OP_SETPC  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_ILLEGAL = 2'd1,
      ST_INVALID = 2'd2,
      ST_HALTED  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DIV,
      S_EXEC,
      S_DONE
   } state_type;

   localparam logic [3:0] OPC_BR    = 4'd0;
   localparam logic [3:0] OPC_ARITH = 4'd1;
   localparam logic [3:0] OPC_CMP   = 4'd2;
   localparam logic [3:0] OPC_JSR   = 4'd4;
   localparam logic [3:0] OPC_LOGIC = 4'd5;
   localparam logic [3:0] OPC_LDR   = 4'd6;
   localparam logic [3:0] OPC_STR   = 4'd7;
   localparam logic [3:0] OPC_RTI   = 4'd8;
   localparam logic [3:0] OPC_CONST = 4'd9;
   localparam logic [3:0] OPC_SHIFT = 4'd10;
   localparam logic [3:0] OPC_JMP   = 4'd12;
   localparam logic [3:0] OPC_HICON = 4'd13;
   localparam logic [3:0] OPC_TRAP  = 4'd15;

   localparam logic [15:0] PC_RESET  = 16'h8200;
   localparam logic [15:0] PSR_RESET = 16'h8002;

   function automatic logic [2:0] nzp_of(input logic [15:0] v);
      logic [2:0] r;
      if (v == 16'h0) r = 3'b010;
      else if (v[15]) r = 3'b100;
      else r = 3'b001;
      return r;
   endfunction

endpackage

// ----- src/lc4_instruction_execute.sv -----
// channel   | ports                                   | direction
// request   | start, busy, req_*                      | in (busy out)
// response  | rsp_strobe, rsp_*                       | out
//
// operands are registered at acceptance; the result strobe then follows data memory
// read, execute and result. busy drops the cycle after; no request is taken while busy.
// divide and modulo wait for the shared bit-serial divider between read and execute.
// reset clears registers, pc, psr and halt; data memory is not cleared.
// the receiver cannot stall; each result is shown for one cycle.
module lc4_instruction_execute
   import lc4_pkg::*;
#(
   parameter int MEM_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [15:0] req_instruction,
   input  logic [15:0] req_mem_address,
   input  logic [15:0] req_write_data,
   input  logic [2:0]  req_reg_select,
   input  logic [15:0] req_new_psr,
   output logic        rsp_strobe,
   output logic [15:0] rsp_pc_after,
   output logic [15:0] rsp_psr_after,
   output logic        rsp_reg_written,
   output logic [2:0]  rsp_dest_reg,
   output logic [15:0] rsp_dest_value,
   output logic        rsp_mem_written,
   output logic [15:0] rsp_store_address,
   output logic [15:0] rsp_store_value,
   output logic [1:0]  rsp_status
);
   localparam int AW = $clog2(MEM_WORDS);

   state_type   state_ff, state_in;
   logic [15:0] regs_ff [8];
   logic [15:0] pc_ff, pc_in, psr_ff, psr_in;
   logic        halt_ff, halt_in;
   logic [1:0]  op_ff;
   logic [15:0] ins_ff, maddr_ff, wdata_ff, npsr_ff;
   logic [2:0]  rsel_ff;
   logic [15:0] a_ff, b_ff, r_ff, r7_ff;

   logic        rw_ff, rw_in, mw_ff, mw_in;
   logic [2:0]  dreg_ff, dreg_in;
   logic [15:0] dval_ff, dval_in, sa_ff, sa_in, sv_ff, sv_in;
   status_type  st_ff, st_in;

   logic        mem_we, div_start, div_done;
   logic [15:0] mem_rdata, quo, rem;
   logic [15:0] mem_waddr, mem_wdata, ldaddr;

   logic [3:0]  opc;
   logic [2:0]  rd;
   assign opc = ins_ff[15:12];
   assign rd  = ins_ff[11:9];
   assign ldaddr = a_ff + {{10{ins_ff[5]}}, ins_ff[5:0]};

   lc4_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(mem_we), .wr_addr(mem_waddr[AW-1:0]),
      .wr_data(mem_wdata), .rd_addr(ldaddr[AW-1:0]), .rd_data(mem_rdata)
   );

   lc4_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(a_ff),
      .divisor(b_ff), .done(div_done), .quotient(quo), .remainder(rem)
   );

   function automatic logic code_ok(input logic [15:0] t, input logic priv);
      logic ok;
      ok = 1'b1;
      if ((t >= 16'h2000 && t < 16'h8000) || t >= 16'hA000) ok = 1'b0;
      if (t >= 16'h8000 && !priv) ok = 1'b0;
      return ok;
   endfunction

   function automatic logic data_ok(input logic [15:0] t, input logic priv);
      logic ok;
      ok = 1'b1;
      if (t < 16'h2000) ok = 1'b0;
      if (t >= 16'h8000 && t < 16'hA000) ok = 1'b0;
      if (t >= 16'hA000 && !priv) ok = 1'b0;
      return ok;
   endfunction

   logic        is_div;
   assign is_div = op_ff == OP_EXEC && !halt_ff &&
                   ((opc == OPC_ARITH && ins_ff[5:3] == 3'd3) ||
                    (opc == OPC_SHIFT && ins_ff[5:4] == 2'd3));

   // execute stage
   logic [15:0] pc1, npc, x, y;
   logic        sgn, lt, gt;
   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff; psr_in = psr_ff; halt_in = halt_ff;
      rw_in = rw_ff; mw_in = mw_ff; dreg_in = dreg_ff; dval_in = dval_ff;
      sa_in = sa_ff; sv_in = sv_ff; st_in = st_ff;
      mem_we = 1'b0; mem_waddr = sa_ff; mem_wdata = sv_ff;
      div_start = 1'b0;
      pc1 = pc_ff + 16'd1;
      npc = pc1;
      x = 16'h0; y = 16'h0; sgn = 1'b0; lt = 1'b0; gt = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_READ;
         end
         S_READ: begin
            if (is_div) begin
               div_start = 1'b1;
               state_in = S_DIV;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            rw_in = 1'b0; mw_in = 1'b0; dreg_in = 3'd0; dval_in = 16'h0;
            sa_in = 16'h0; sv_in = 16'h0; st_in = ST_OK;
            if (halt_ff) begin
               st_in = ST_HALTED;
            end else begin
               case (op_ff)
                  OP_WRMEM: begin
                     mw_in = 1'b1; sa_in = maddr_ff; sv_in = wdata_ff;
                     mem_we = 1'b1; mem_waddr = maddr_ff; mem_wdata = wdata_ff;
                  end
                  OP_WRREG: begin
                     rw_in = 1'b1; dreg_in = rsel_ff; dval_in = wdata_ff;
                  end
                  OP_SETPC: begin
                     pc_in = wdata_ff; psr_in = npsr_ff;
                  end
                  default: begin
                     case (opc)
                        OPC_BR: begin
                           if ((psr_ff[2:0] & rd) != 3'd0)
                              npc = pc1 + {{7{ins_ff[8]}}, ins_ff[8:0]};
                           if (!code_ok(npc, psr_ff[15])) st_in = ST_ILLEGAL;
                        end
                        OPC_ARITH: begin
                           rw_in = 1'b1; dreg_in = rd;
                           case (ins_ff[5:3])
                              3'd0: dval_in = a_ff + b_ff;
                              3'd1: dval_in = 16'(a_ff * b_ff);
                              3'd2: dval_in = a_ff - b_ff;
                              3'd3: dval_in = quo;
                              default: dval_in = a_ff + {{11{ins_ff[4]}}, ins_ff[4:0]};
                           endcase
                        end
                        OPC_CMP: begin
                           case (ins_ff[8:7])
                              2'd0: begin x = r_ff; y = b_ff; sgn = 1'b1; end
                              2'd1: begin x = r_ff; y = b_ff; end
                              2'd2: begin
                                 x = r_ff; y = {{9{ins_ff[6]}}, ins_ff[6:0]}; sgn = 1'b1;
                              end
                              default: begin x = r_ff; y = {9'd0, ins_ff[6:0]}; end
                           endcase
                           if (sgn) begin
                              lt = $signed(x) < $signed(y); gt = $signed(x) > $signed(y);
                           end else begin
                              lt = x < y; gt = x > y;
                           end
                           psr_in = {psr_ff[15], 12'd0, lt ? 3'b100 : (gt ? 3'b001 : 3'b010)};
                        end
                        OPC_JSR: begin
                           npc = ins_ff[11] ? {pc_ff[15], ins_ff[10:0], 4'd0} : a_ff;
                           rw_in = 1'b1; dreg_in = 3'd7; dval_in = pc1;
                        end
                        OPC_LOGIC: begin
                           rw_in = 1'b1; dreg_in = rd;
                           case (ins_ff[5:3])
                              3'd0: dval_in = a_ff & b_ff;
                              3'd1: dval_in = ~a_ff;
                              3'd2: dval_in = a_ff | b_ff;
                              3'd3: dval_in = a_ff ^ b_ff;
                              default: dval_in = a_ff & {{11{ins_ff[4]}}, ins_ff[4:0]};
                           endcase
                        end
                        OPC_LDR, OPC_STR: begin
                           if (!data_ok(ldaddr, psr_ff[15])) begin
                              st_in = ST_ILLEGAL;
                           end else if (opc == OPC_LDR) begin
                              rw_in = 1'b1; dreg_in = rd; dval_in = mem_rdata;
                           end else begin
                              mw_in = 1'b1; sa_in = ldaddr; sv_in = r_ff;
                              mem_we = 1'b1; mem_waddr = ldaddr; mem_wdata = r_ff;
                           end
                        end
                        OPC_RTI: begin
                           npc = r7_ff;
                           psr_in = {1'b0, psr_ff[14:0]};
                        end
                        OPC_CONST: begin
                           rw_in = 1'b1; dreg_in = rd;
                           dval_in = {{7{ins_ff[8]}}, ins_ff[8:0]};
                        end
                        OPC_SHIFT: begin
                           rw_in = 1'b1; dreg_in = rd;
                           case (ins_ff[5:4])
                              2'd0: dval_in = a_ff << ins_ff[3:0];
                              2'd1: dval_in = 16'($signed(a_ff) >>> ins_ff[3:0]);
                              2'd2: dval_in = a_ff >> ins_ff[3:0];
                              default: dval_in = rem;
                           endcase
                        end
                        OPC_JMP: begin
                           npc = ins_ff[11] ? pc1 + {{5{ins_ff[10]}}, ins_ff[10:0]} : a_ff;
                           if (!code_ok(npc, psr_ff[15])) st_in = ST_ILLEGAL;
                        end
                        OPC_HICON: begin
                           rw_in = 1'b1; dreg_in = rd;
                           dval_in = {ins_ff[7:0], r_ff[7:0]};
                        end
                        OPC_TRAP: begin
                           npc = {8'h80, ins_ff[7:0]};
                           psr_in = {1'b1, psr_ff[14:0]};
                           rw_in = 1'b1; dreg_in = 3'd7; dval_in = pc1;
                        end
                        default: st_in = ST_INVALID;
                     endcase
                     if (st_in == ST_ILLEGAL) begin
                        halt_in = 1'b1;
                        psr_in = psr_ff;
                        mem_we = 1'b0;
                        rw_in = 1'b0; mw_in = 1'b0; dreg_in = 3'd0; dval_in = 16'h0;
                        sa_in = 16'h0; sv_in = 16'h0;
                     end else begin
                        pc_in = npc;
                        if (rw_in) psr_in = {psr_in[15], 12'd0, nzp_of(dval_in)};
                     end
                  end
               endcase
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pc_ff <= PC_RESET;
         psr_ff <= PSR_RESET;
         halt_ff <= 1'b0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'h0;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         psr_ff <= psr_in;
         halt_ff <= halt_in;
         if (state_ff == S_EXEC && rw_in) regs_ff[dreg_in] <= dval_in;
      end
      if (state_ff == S_IDLE && start) begin
         op_ff <= req_operation; ins_ff <= req_instruction;
         maddr_ff <= req_mem_address; wdata_ff <= req_write_data;
         rsel_ff <= req_reg_select; npsr_ff <= req_new_psr;
      end
      // operand read is registered at acceptance, ahead of the data memory read that uses it
      if (state_ff == S_IDLE) begin
         a_ff <= regs_ff[req_instruction[8:6]];
         b_ff <= regs_ff[req_instruction[2:0]];
         r_ff <= regs_ff[req_instruction[11:9]];
         r7_ff <= regs_ff[7];
      end
      rw_ff <= rw_in; mw_ff <= mw_in; dreg_ff <= dreg_in; dval_ff <= dval_in;
      sa_ff <= sa_in; sv_ff <= sv_in; st_ff <= st_in;
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_strobe        = state_ff == S_DONE;
   assign rsp_pc_after      = pc_ff;
   assign rsp_psr_after     = psr_ff;
   assign rsp_reg_written   = rw_ff;
   assign rsp_dest_reg      = dreg_ff;
   assign rsp_dest_value    = dval_ff;
   assign rsp_mem_written   = mw_ff;
   assign rsp_store_address = sa_ff;
   assign rsp_store_value   = sv_ff;
   assign rsp_status        = st_ff;
endmodule

// ----- src/lc4_ram.sv -----
module lc4_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- src/lc4_div.sv -----
module lc4_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient,
   output logic [15:0] remainder
);
   logic [15:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, qneg_ff, qneg_in, rneg_ff, rneg_in, zero_ff, zero_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [15:0] rsh;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; qneg_in = qneg_ff; rneg_in = rneg_ff; zero_in = zero_ff;
      done_in = 1'b0;
      rsh = {r_ff[14:0], q_ff[15]};
      trial = {1'b0, rsh} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend[15] ? 16'(-dividend) : dividend;
         d_in = divisor[15] ? 16'(-divisor) : divisor;
         r_in = 16'h0;
         cnt_in = 5'd16;
         busy_in = 1'b1;
         qneg_in = dividend[15] ^ divisor[15];
         rneg_in = dividend[15];
         zero_in = (divisor == 16'h0);
      end else if (busy_ff) begin
         if (!trial[16]) begin
            r_in = trial[15:0];
            q_in = {q_ff[14:0], 1'b1};
         end else begin
            r_in = rsh;
            q_in = {q_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in; zero_ff <= zero_in;
   end

   assign done      = done_ff;
   assign quotient  = zero_ff ? 16'h0 : (qneg_ff ? 16'(-q_ff) : q_ff);
   assign remainder = zero_ff ? 16'h0 : (rneg_ff ? 16'(-r_ff) : r_ff);
endmodule
